/* rtl/b64sd_pkg.sv */
// ----------------------------------------------------------------------------
// b64sd_pkg
// Status codes and character constants for the streaming Base64 decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  typedef logic [1:0] status_t;
  typedef logic [5:0] sextet_t;

  localparam status_t STATUS_OK          = 2'd0;
  localparam status_t STATUS_BAD_CHAR    = 2'd1;
  localparam status_t STATUS_DATA_AFTER  = 2'd2;
  localparam status_t STATUS_BAD_PADDING = 2'd3;

  // Sextet values at the start of each alphabet range
  localparam sextet_t SEXTET_LOWER_BASE = 6'd26;
  localparam sextet_t SEXTET_DIGIT_BASE = 6'd52;
  localparam sextet_t SEXTET_PLUS       = 6'd62;
  localparam sextet_t SEXTET_SLASH      = 6'd63;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;

endpackage

/* rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder: one text character in, one result item out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one character per item, or an
//   end marker (in_end_of_text = 1, character ignored). Every input item
//   gives exactly one result item on the output channel (out_valid /
//   out_stall): a decoded byte when out_byte_valid is set, the sticky status
//   on every item, and out_finished with the final status on the end marker.
//   Whitespace items return a result with no byte.
// Timing:
//   An input register, then the decode logic into the result register.
//   Throughput is 1 item per cycle while out_stall is low; the decode state is a
//   handful of flops updated in one pass per item.
// Reset:
//   rst_n (synchronous, active low) clears the pipeline and decode state.
//   The end marker also returns the decode state to zero.
// Stall:
//   While out_stall holds a waiting result, the input register still takes
//   one item; in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module base64_stream_decoder
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_byte_valid,
  output logic [7:0] out_data_byte,
  output logic       out_finished,
  output logic [1:0] out_status
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_end_r;

  // decode state
  logic [1:0] slot_count_r,   slot_count_nxt;
  sextet_t    prev_sextet_r,  prev_sextet_nxt;
  logic       padding_seen_r, padding_seen_nxt;
  logic       stopped_r,      stopped_nxt;
  status_t    error_r,        error_nxt;

  // result register
  logic       out_valid_r;
  logic       byte_valid_r, byte_valid_nxt;
  logic [7:0] data_byte_r,  data_byte_nxt;
  logic       finished_r;
  status_t    status_r,     status_nxt;

  logic adv_out;
  logic s1_fire;
  logic in_fire;

  assign adv_out  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv_out;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_fire  = in_valid && !in_stall;

  // character classes
  logic    is_upper, is_lower, is_digit, is_plus, is_slash, is_pad, is_space;
  logic    is_data;
  sextet_t sextet;

  always_comb begin
    is_upper = (s1_char_r >= CHAR_UPPER_A) && (s1_char_r <= CHAR_UPPER_Z);
    is_lower = (s1_char_r >= CHAR_LOWER_A) && (s1_char_r <= CHAR_LOWER_Z);
    is_digit = (s1_char_r >= CHAR_ZERO) && (s1_char_r <= CHAR_NINE);
    is_plus  = (s1_char_r == CHAR_PLUS);
    is_slash = (s1_char_r == CHAR_SLASH);
    is_pad   = (s1_char_r == CHAR_EQUALS);
    is_space = (s1_char_r == CHAR_SPACE) || (s1_char_r == CHAR_TAB) ||
               (s1_char_r == CHAR_CR) || (s1_char_r == CHAR_LF);
    is_data  = is_upper || is_lower || is_digit || is_plus || is_slash;

    priority if (is_upper) begin
      sextet = 6'(s1_char_r - CHAR_UPPER_A);
    end else if (is_lower) begin
      sextet = 6'(s1_char_r - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
    end else if (is_digit) begin
      sextet = 6'(s1_char_r - CHAR_ZERO) + SEXTET_DIGIT_BASE;
    end else if (is_plus) begin
      sextet = SEXTET_PLUS;
    end else begin
      sextet = SEXTET_SLASH;
    end
  end

  always_comb begin
    slot_count_nxt   = slot_count_r;
    prev_sextet_nxt  = prev_sextet_r;
    padding_seen_nxt = padding_seen_r;
    stopped_nxt      = stopped_r;
    error_nxt        = error_r;
    byte_valid_nxt   = 1'b0;
    data_byte_nxt    = 8'd0;
    status_nxt       = error_r;

    if (s1_end_r) begin
      if (error_r == STATUS_OK && padding_seen_r && slot_count_r != 2'd0) begin
        status_nxt = STATUS_BAD_PADDING;
      end
      // lone sextet left at the end of the text
      if (status_nxt == STATUS_OK && slot_count_r == 2'd1) begin
        byte_valid_nxt = 1'b1;
        data_byte_nxt  = {prev_sextet_r, 2'b00};
      end
      slot_count_nxt   = 2'd0;
      prev_sextet_nxt  = '0;
      padding_seen_nxt = 1'b0;
      stopped_nxt      = 1'b0;
      error_nxt        = STATUS_OK;
    end else if (error_r == STATUS_OK && !stopped_r) begin
      priority if (!is_data && !is_pad && !is_space) begin
        error_nxt = STATUS_BAD_CHAR;
      end else if (is_space) begin
        // skipped
      end else if (padding_seen_r && is_data) begin
        error_nxt = STATUS_DATA_AFTER;
      end else if (is_pad) begin
        if (slot_count_r == 2'd0) begin
          stopped_nxt = 1'b1;
        end else begin
          if (slot_count_r == 2'd1) begin
            byte_valid_nxt = 1'b1;
            data_byte_nxt  = {prev_sextet_r, 2'b00};
          end
          padding_seen_nxt = 1'b1;
          slot_count_nxt   = slot_count_r + 2'd1;
          if (slot_count_r == 2'd3) begin
            stopped_nxt = 1'b1;
          end
        end
      end else begin
        unique case (slot_count_r)
          2'd1: begin
            byte_valid_nxt = 1'b1;
            data_byte_nxt  = {prev_sextet_r, sextet[5:4]};
          end
          2'd2: begin
            byte_valid_nxt = 1'b1;
            data_byte_nxt  = {prev_sextet_r[3:0], sextet[5:2]};
          end
          2'd3: begin
            byte_valid_nxt = 1'b1;
            data_byte_nxt  = {prev_sextet_r[1:0], sextet};
          end
          default: begin
          end
        endcase
        prev_sextet_nxt = sextet;
        slot_count_nxt  = slot_count_r + 2'd1;
      end
      status_nxt = error_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      slot_count_r   <= 2'd0;
      prev_sextet_r  <= '0;
      padding_seen_r <= 1'b0;
      stopped_r      <= 1'b0;
      error_r        <= STATUS_OK;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r    <= 1'b1;
        slot_count_r   <= slot_count_nxt;
        prev_sextet_r  <= prev_sextet_nxt;
        padding_seen_r <= padding_seen_nxt;
        stopped_r      <= stopped_nxt;
        error_r        <= error_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_char_code;
      s1_end_r  <= in_end_of_text;
    end
    if (s1_fire) begin
      byte_valid_r <= byte_valid_nxt;
      data_byte_r  <= data_byte_nxt;
      finished_r   <= s1_end_r;
      status_r     <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_valid = byte_valid_r;
  assign out_data_byte  = data_byte_r;
  assign out_finished   = finished_r;
  assign out_status     = status_r;

  // decoding only stops on a group boundary
  a_stop_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> slot_count_r == 2'd0)
    else $error("decode stopped inside a group");

  // padding always leaves at least two slots filled, or a full group
  a_pad_slots: assert property (@(posedge clk) disable iff (!rst_n)
    padding_seen_r |-> slot_count_r != 2'd1)
    else $error("padding with a single slot filled");

  // an error result never carries a byte
  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> !out_byte_valid)
    else $error("byte emitted with error status");

  // the end marker leaves clean state behind
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_end_r) |=>
      (slot_count_r == 2'd0 && error_r == STATUS_OK && !padding_seen_r && !stopped_r))
    else $error("state not cleared after end marker");

  // a result held on the channel under stall is not replaced
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) && $stable(out_finished)))
    else $error("stalled result changed");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_stream_decoder. Directed strings cover the
// alphabet ends, whitespace, padding and every error. Random messages follow:
// mostly valid encodings with random content, plus noise and damaged text.
// Both channels idle at random, and the receiver holds off once for a long
// stretch. Every result is checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;
  import b64sd_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {KIND_DATA, KIND_PAD, KIND_SPACE, KIND_BAD} char_kind_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       finished;
    status_t    status;
  } decode_result_t;

  // Decoder state mirror plus the queue of results still owed by the block
  class b64_scoreboard;
    logic [1:0]     slot_count;
    sextet_t        last_sextet;
    bit             pad_seen;
    bit             stopped;
    status_t        err;
    decode_result_t owed[$];
    int             errors;
    int             checked;
    int             messages;
    int             bytes_out;
    int             status_hist[4];

    function new();
      clear_state();
      errors     = 0;
      checked    = 0;
      messages   = 0;
      bytes_out  = 0;
      foreach (status_hist[i]) status_hist[i] = 0;
    endfunction

    function void clear_state();
      slot_count  = '0;
      last_sextet = '0;
      pad_seen    = 1'b0;
      stopped     = 1'b0;
      err         = STATUS_OK;
    endfunction

    function char_kind_t classify(input logic [7:0] c, output sextet_t sx);
      sx = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
        sx = sextet_t'(c - CHAR_UPPER_A);
        return KIND_DATA;
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
        sx = sextet_t'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        return KIND_DATA;
      end
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        sx = sextet_t'(c - CHAR_ZERO) + SEXTET_DIGIT_BASE;
        return KIND_DATA;
      end
      if (c == CHAR_PLUS) begin
        sx = SEXTET_PLUS;
        return KIND_DATA;
      end
      if (c == CHAR_SLASH) begin
        sx = SEXTET_SLASH;
        return KIND_DATA;
      end
      if (c == CHAR_EQUALS) return KIND_PAD;
      if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) return KIND_SPACE;
      return KIND_BAD;
    endfunction

    function void note_item(input logic [7:0] ch, input logic eot);
      decode_result_t r;
      char_kind_t     kind;
      sextet_t        sx;
      r = '0;
      if (eot) begin
        messages++;
        r.finished = 1'b1;
        r.status   = err;
        if (r.status == STATUS_OK && pad_seen && slot_count != 0)
          r.status = STATUS_BAD_PADDING;
        // lone sextet left in the group is flushed as a byte
        if (r.status == STATUS_OK && slot_count == 2'd1) begin
          r.byte_valid = 1'b1;
          r.data_byte  = {last_sextet, 2'b00};
        end
        status_hist[r.status]++;
        clear_state();
      end else begin
        if (err == STATUS_OK && !stopped) begin
          kind = classify(ch, sx);
          case (kind)
            KIND_BAD: err = STATUS_BAD_CHAR;
            KIND_SPACE: ;
            KIND_PAD: begin
              if (slot_count == 2'd0) begin
                stopped = 1'b1;
              end else begin
                if (slot_count == 2'd1) begin
                  r.byte_valid = 1'b1;
                  r.data_byte  = {last_sextet, 2'b00};
                end
                pad_seen   = 1'b1;
                slot_count = slot_count + 2'd1;
                if (slot_count == 2'd0) stopped = 1'b1;
              end
            end
            default: begin
              if (pad_seen) begin
                err = STATUS_DATA_AFTER;
              end else begin
                case (slot_count)
                  2'd1: r.data_byte = {last_sextet, sx[5:4]};
                  2'd2: r.data_byte = {last_sextet[3:0], sx[5:2]};
                  2'd3: r.data_byte = {last_sextet[1:0], sx};
                  default: ;
                endcase
                r.byte_valid = (slot_count != 2'd0);
                last_sextet  = sx;
                slot_count   = slot_count + 2'd1;
              end
            end
          endcase
        end
        r.status = err;
      end
      if (r.byte_valid) bytes_out++;
      owed.push_back(r);
    endfunction

    function void check_result(input logic bv, input logic [7:0] db, input logic fin,
                               input status_t st);
      decode_result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no item pending: bv=%0b byte=%02h fin=%0b st=%0d",
                   $time, bv, db, fin, st);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (bv !== want.byte_valid || db !== want.data_byte || fin !== want.finished ||
          st !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %0d bv/byte/fin/st exp %0b/%02h/%0b/%0d got %0b/%02h/%0b/%0d",
                   $time, checked, want.byte_valid, want.data_byte, want.finished,
                   want.status, bv, db, fin, st);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic       out_byte_valid;
  logic [7:0] out_data_byte;
  logic       out_finished;
  logic [1:0] out_status;

  b64_scoreboard sb = new();
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;
  int items_sent;
  int cycle_count;

  base64_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_valid (out_byte_valid),
    .out_data_byte  (out_data_byte),
    .out_finished   (out_finished),
    .out_status     (out_status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_stream_decoder verification failed");
      $finish;
    end
  end

  // Both handshakes are sampled on pre-edge values; inputs before results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_char_code, in_end_of_text);
      if (out_valid && !out_stall)
        sb.check_result(out_byte_valid, out_data_byte, out_finished, out_status);
    end
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= rst_n && rx_gaps && ($urandom_range(99) < 12);
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eot);
    while (tx_gaps && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= ch;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] sextet_char(input sextet_t s);
    if (s < SEXTET_LOWER_BASE) return CHAR_UPPER_A + 8'(s);
    if (s < SEXTET_DIGIT_BASE) return CHAR_LOWER_A + 8'(s - SEXTET_LOWER_BASE);
    if (s < SEXTET_PLUS) return CHAR_ZERO + 8'(s - SEXTET_DIGIT_BASE);
    if (s == SEXTET_PLUS) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  // One message: mostly a valid encoding, sometimes noise or damaged text
  task automatic send_message();
    logic [7:0]  txt[$];
    logic [7:0]  raw[$];
    logic [7:0]  spaces[4];
    logic [23:0] grp;
    int          nbytes;
    int          rem;
    int          mode;
    int          pos;
    bit          keep_pad;
    spaces   = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
    nbytes   = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
    keep_pad = ($urandom_range(3) != 0);
    for (int i = 0; i < nbytes; i++) raw.push_back(8'($urandom_range(255)));
    for (int i = 0; i < nbytes; i += 3) begin
      rem = nbytes - i;
      grp = {raw[i], (rem > 1) ? raw[i+1] : 8'h00, (rem > 2) ? raw[i+2] : 8'h00};
      txt.push_back(sextet_char(grp[23:18]));
      txt.push_back(sextet_char(grp[17:12]));
      if (rem > 1) txt.push_back(sextet_char(grp[11:6]));
      else if (keep_pad) txt.push_back(CHAR_EQUALS);
      if (rem > 2) txt.push_back(sextet_char(grp[5:0]));
      else if (keep_pad) txt.push_back(CHAR_EQUALS);
    end
    mode = $urandom_range(99);
    if (mode < 10) begin
      txt.delete();
      repeat ($urandom_range(12, 1)) txt.push_back(8'($urandom_range(255)));
    end else if (mode < 30) begin
      pos = (txt.size() > 0) ? $urandom_range(txt.size() - 1) : 0;
      case ($urandom_range(3))
        0: if (txt.size() > 0) txt[pos] = 8'($urandom_range(255));
        1: txt.insert(pos, CHAR_EQUALS);
        2: if (txt.size() > 0) void'(txt.pop_back());
        default: begin
          txt.push_back(CHAR_EQUALS);
          txt.push_back(sextet_char(sextet_t'($urandom_range(63))));
        end
      endcase
    end
    foreach (txt[i]) begin
      if ($urandom_range(99) < 8) send_item(spaces[$urandom_range(3)], 1'b0);
      send_item(txt[i], 1'b0);
    end
    send_end();
  endtask

  initial begin
    bit held;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = 8'h00;
    in_end_of_text = 1'b0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    hold_req       = 1'b0;
    held           = 1'b0;
    items_sent     = 0;
    cycle_count    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alphabet ends, two full groups
    send_text("AZaz09+/");
    send_end();
    // every whitespace code, then a lone sextet flushed at the end
    send_item(CHAR_SPACE, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_text("Q");
    send_end();
    // pad in the second slot emits a byte; data after it is an error
    send_text("Q=A");
    send_end();
    // partial padded group at the end
    send_text("QQ=");
    send_end();
    // pad in the first slot stops decoding, later data ignored
    send_text("=A");
    send_end();
    // invalid codes, sticky
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("A");
    send_end();

    pos_loop: while (items_sent < RANDOM_ITEMS) begin
      if (!held && items_sent >= 300) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      tx_gaps = !(items_sent >= 700 && items_sent < 1000);
      rx_gaps = tx_gaps;
      send_message();
    end
    in_valid <= 1'b0;
    // let the monitor take the last accepted item before counting what is owed
    @(posedge clk);

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d messages; %0d results checked, %0d bytes decoded",
             items_sent, sb.messages, sb.checked, sb.bytes_out);
    $display("End status ok/bad char/data after pad/bad pad: %0d/%0d/%0d/%0d; %0d mismatches",
             sb.status_hist[0], sb.status_hist[1], sb.status_hist[2], sb.status_hist[3],
             sb.errors);
    if (sb.errors == 0) begin
      $display("base64_stream_decoder verification clean");
    end else begin
      $display("base64_stream_decoder verification failed");
    end
    $finish;
  end

endmodule

/* base64_stream_decoder.f */
rtl/b64sd_pkg.sv
rtl/base64_stream_decoder.sv
tb/testbench.sv
